/* rtl/core/uihp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uihp_pkg: shared types, constants and microcode for the heading poller
// Holds the sensor protocol bytes, phase and ack codes, the control word
// layout, and the read-only microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package uihp_pkg;

  // Microprogram counter width
  localparam int PC_W = 5;

  // Sensor phases (reported as phase_code)
  localparam logic [2:0] PH_RESET = 3'd0;
  localparam logic [2:0] PH_INIT1 = 3'd1;
  localparam logic [2:0] PH_WAIT  = 3'd2;
  localparam logic [2:0] PH_INIT2 = 3'd3;
  localparam logic [2:0] PH_INIT3 = 3'd4;
  localparam logic [2:0] PH_INIT4 = 3'd5;
  localparam logic [2:0] PH_READY = 3'd6;
  localparam logic [2:0] PH_ERROR = 3'd7;

  // Ack status codes
  localparam logic [2:0] ACK_NONE   = 3'd0;
  localparam logic [2:0] ACK_OK     = 3'd1;
  localparam logic [2:0] ACK_SHORT  = 3'd2;
  localparam logic [2:0] ACK_HEADER = 3'd3;
  localparam logic [2:0] ACK_DEVICE = 3'd4;

  // Input commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ZERO    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ENABLED = 1'b0;
  localparam logic CFG_WAIT    = 1'b1;

  localparam logic [7:0] WAIT_TICKS_RST = 8'd50;

  // Protocol bytes
  localparam logic [7:0] START_BYTE    = 8'hAA;
  localparam logic [7:0] RESP_BYTE     = 8'hBB;
  localparam logic [7:0] ERR_BYTE      = 8'hEE;
  localparam logic [7:0] OP_WRITE      = 8'h00;
  localparam logic [7:0] OP_READ       = 8'h01;
  localparam logic [7:0] LEN_ONE       = 8'h01;
  localparam logic [7:0] LEN_HEADING   = 8'h02;
  localparam logic [7:0] ACK_GOOD      = 8'h01;
  localparam logic [7:0] REG_SYS_TRIG  = 8'h3F;
  localparam logic [7:0] REG_PWR_MODE  = 8'h3E;
  localparam logic [7:0] REG_OPR_MODE  = 8'h3D;
  localparam logic [7:0] REG_HEADING   = 8'h1A;
  localparam logic [7:0] VAL_CLK_SEL   = 8'h20;
  localparam logic [7:0] VAL_RST_SYS   = 8'h80;
  localparam logic [7:0] VAL_PWR_NORM  = 8'h00;
  localparam logic [7:0] VAL_MODE_NDOF = 8'b0000_1100;

  // Frame lengths and receive caps
  localparam logic [2:0] LEN_WRITE_FRM = 3'd5;
  localparam logic [2:0] LEN_REQ_FRM   = 3'd4;
  localparam logic [2:0] RX_CAP        = 3'd4;
  localparam logic [2:0] ACK_LEN       = 3'd2;

  // Heading wrap, 1/16 degree units
  localparam logic signed [16:0] HALF_TURN     = 17'sd2880;
  localparam logic signed [16:0] NEG_HALF_TURN = -17'sd2880;
  localparam logic signed [16:0] FULL_TURN     = 17'sd5760;

  typedef logic [PC_W-1:0] upc_t;

  // Microprogram addresses
  localparam upc_t UA_IDLE      = 5'd0;
  localparam upc_t UA_DISPATCH  = 5'd1;
  localparam upc_t UA_ZERO      = 5'd2;
  localparam upc_t UA_RESTART   = 5'd3;
  localparam upc_t UA_NOP       = 5'd4;
  localparam upc_t UA_T_RESET   = 5'd5;  // tick routines follow in phase order
  localparam upc_t UA_T_INIT1   = 5'd6;
  localparam upc_t UA_T_WAIT    = 5'd7;
  localparam upc_t UA_T_INIT2   = 5'd8;
  localparam upc_t UA_T_INIT3   = 5'd9;
  localparam upc_t UA_T_INIT4   = 5'd10;
  localparam upc_t UA_T_READY   = 5'd11;
  localparam upc_t UA_T_ERROR   = 5'd12;
  localparam upc_t UA_HEAD_ZERO = 5'd13;
  localparam upc_t UA_HEAD_HELD = 5'd14;
  localparam upc_t UA_WRAP      = 5'd15;
  localparam upc_t UA_EMIT      = 5'd16;
  localparam upc_t UA_END       = 5'd17;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ZERO,
    ACT_RESTART,
    ACT_T_RESET,
    ACT_T_INIT1,
    ACT_T_WAIT,
    ACT_T_INIT2,
    ACT_T_INIT3,
    ACT_T_INIT4,
    ACT_T_READY,
    ACT_T_ERROR,
    ACT_HEAD_ZERO,
    ACT_HEAD_HELD,
    ACT_WRAP,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_NO_ACCEPT,
    COND_DISPATCH,
    COND_WRAP_BUSY,
    COND_EMIT_MORE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
    logic  rdy;
    logic  wait_out;
  } uword_t;

  // Sequencer -> datapath
  typedef struct packed {
    act_t act;
    logic rdy;
    logic accept;
  } uihp_ctl_t;

  // Datapath -> sequencer
  typedef struct packed {
    logic       in_valid;
    logic       out_free;
    logic [1:0] cmd;
    logic       enabled;
    logic [2:0] phase;
    logic       wrap_busy;
    logic       emit_more;
  } uihp_stat_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{act: ACT_NONE, cond: COND_JUMP, target: UA_IDLE, rdy: 1'b0, wait_out: 1'b0};
    case (pc)
      UA_IDLE: begin
        w.rdy    = 1'b1;
        w.cond   = COND_NO_ACCEPT;
        w.target = UA_IDLE;
      end
      UA_DISPATCH: w.cond = COND_DISPATCH;
      UA_ZERO: begin
        w.act    = ACT_ZERO;
        w.target = UA_EMIT;
      end
      UA_RESTART: begin
        w.act    = ACT_RESTART;
        w.target = UA_EMIT;
      end
      UA_NOP: w.target = UA_EMIT;
      UA_T_RESET: begin
        w.act    = ACT_T_RESET;
        w.target = UA_HEAD_ZERO;
      end
      UA_T_INIT1: begin
        w.act    = ACT_T_INIT1;
        w.target = UA_HEAD_ZERO;
      end
      UA_T_WAIT: begin
        w.act    = ACT_T_WAIT;
        w.target = UA_HEAD_ZERO;
      end
      UA_T_INIT2: begin
        w.act    = ACT_T_INIT2;
        w.target = UA_HEAD_ZERO;
      end
      UA_T_INIT3: begin
        w.act    = ACT_T_INIT3;
        w.target = UA_HEAD_ZERO;
      end
      UA_T_INIT4: begin
        w.act    = ACT_T_INIT4;
        w.target = UA_HEAD_ZERO;
      end
      UA_T_READY: begin
        w.act    = ACT_T_READY;
        w.target = UA_HEAD_HELD;
      end
      UA_T_ERROR: begin
        w.act    = ACT_T_ERROR;
        w.target = UA_HEAD_ZERO;
      end
      UA_HEAD_ZERO: begin
        w.act    = ACT_HEAD_ZERO;
        w.target = UA_WRAP;
      end
      UA_HEAD_HELD: begin
        w.act    = ACT_HEAD_HELD;
        w.target = UA_WRAP;
      end
      UA_WRAP: begin
        w.act    = ACT_WRAP;
        w.cond   = COND_WRAP_BUSY;
        w.target = UA_WRAP;
      end
      UA_EMIT: begin
        w.act      = ACT_EMIT;
        w.cond     = COND_EMIT_MORE;
        w.target   = UA_EMIT;
        w.wait_out = 1'b1;
      end
      UA_END: w.target = UA_IDLE;
      default: w.target = UA_IDLE;
    endcase
    return w;
  endfunction

  // Byte idx of a write frame (AA 00 reg 01 data) or heading request (AA 01 1A 02)
  function automatic logic [7:0] frame_byte(logic req, logic [7:0] reg_addr,
                                            logic [7:0] data, logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = START_BYTE;
      3'd1:    b = req ? OP_READ : OP_WRITE;
      3'd2:    b = req ? REG_HEADING : reg_addr;
      3'd3:    b = req ? LEN_HEADING : LEN_ONE;
      3'd4:    b = data;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/uihp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uihp_in_if: command channel of the heading poller
// Valid/ready channel carrying one command with the head of the receive queue.
// ----------------------------------------------------------------------------
interface uihp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] rx_count;
  logic [7:0] rx_byte0;
  logic [7:0] rx_byte1;
  logic [7:0] rx_byte2;
  logic [7:0] rx_byte3;

  modport source (
    output valid, cmd, rx_count, rx_byte0, rx_byte1, rx_byte2, rx_byte3,
    input  ready
  );
  modport sink (
    input  valid, cmd, rx_count, rx_byte0, rx_byte1, rx_byte2, rx_byte3,
    output ready
  );
endinterface

/* rtl/core/uihp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uihp_out_if: result channel of the heading poller
// Valid/ready channel carrying one frame byte plus per-command status.
// ----------------------------------------------------------------------------
interface uihp_out_if;
  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [7:0]        tx_byte;
  logic              last;
  logic              flush_rx;
  logic [2:0]        rx_consumed;
  logic              heading_update;
  logic signed [12:0] heading_value;
  logic [2:0]        phase_code;
  logic [2:0]        ack_status;
  logic [7:0]        device_code;

  modport source (
    output valid, tx_valid, tx_byte, last, flush_rx, rx_consumed, heading_update,
           heading_value, phase_code, ack_status, device_code,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_byte, last, flush_rx, rx_consumed, heading_update,
           heading_value, phase_code, ack_status, device_code,
    output ready
  );
endinterface

/* rtl/core/uihp_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uihp_seq: microprogram sequencer
// Step counter over the control ROM, with conditional jumps, a dispatch on
// command/phase, and a hold while an emit step waits for the output slot.
// ----------------------------------------------------------------------------
module uihp_seq
  import uihp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  uihp_stat_t stat,
  output uihp_ctl_t  ctl
);

  upc_t   pc_r;
  upc_t   pc_nxt;
  uword_t cw;
  upc_t   disp_pc;
  logic   accept;
  logic   stall;

  assign cw     = ucode(pc_r);
  assign accept = cw.rdy && stat.in_valid;
  assign stall  = cw.wait_out && !stat.out_free;

  always_comb begin
    if (stat.cmd == CMD_ZERO) begin
      disp_pc = UA_ZERO;
    end else if (stat.cmd == CMD_RESTART) begin
      disp_pc = UA_RESTART;
    end else if (stat.cmd == CMD_TICK && stat.enabled) begin
      disp_pc = UA_T_RESET + {2'b00, stat.phase};
    end else begin
      disp_pc = UA_NOP;
    end
  end

  always_comb begin
    pc_nxt = pc_r + upc_t'(1);
    if (stall) begin
      pc_nxt = pc_r;
    end else begin
      case (cw.cond)
        COND_NEXT:      pc_nxt = pc_r + upc_t'(1);
        COND_JUMP:      pc_nxt = cw.target;
        COND_NO_ACCEPT: if (!accept) pc_nxt = cw.target;
        COND_DISPATCH:  pc_nxt = disp_pc;
        COND_WRAP_BUSY: if (stat.wrap_busy) pc_nxt = cw.target;
        COND_EMIT_MORE: if (stat.emit_more) pc_nxt = cw.target;
        default:        pc_nxt = UA_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UA_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl.act    = stall ? ACT_NONE : cw.act;
  assign ctl.rdy    = cw.rdy;
  assign ctl.accept = accept;

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (pc_r == UA_DISPATCH))
    else $error("accepted transaction not dispatched");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(pc_r))
    else $error("step counter moved during output stall");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= UA_END)
    else $error("step counter outside microprogram");
`endif

endmodule

/* rtl/core/uihp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uihp_dp: heading poller datapath
// Config registers, sensor state, transaction latch, ack checks, frame
// builder, heading subtract/wrap, and the registered result slot.
// ----------------------------------------------------------------------------
module uihp_dp
  import uihp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [7:0]   cfg_wdata,
  uihp_in_if.sink      in_ch,
  uihp_out_if.source   out_ch,
  input  uihp_ctl_t    ctl,
  output uihp_stat_t   stat
);

  // configuration
  logic        enabled_r, enabled_nxt;
  logic [7:0]  wait_ticks_r, wait_ticks_nxt;
  // sensor state
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  wait_cnt_r, wait_cnt_nxt;
  logic [15:0] held_raw_r, held_raw_nxt;
  logic [15:0] last_raw_r, last_raw_nxt;
  logic [15:0] offset_r, offset_nxt;
  // latched transaction
  logic [1:0]  cmd_r, cmd_nxt;
  logic [2:0]  avail_r, avail_nxt;
  logic [7:0]  rxb_r [4];
  // per-transaction results
  logic        flush_r, flush_nxt;
  logic [2:0]  used_r, used_nxt;
  logic        upd_r, upd_nxt;
  logic [2:0]  ack_r, ack_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic signed [16:0] hv_r, hv_nxt;
  logic        frm_req_r, frm_req_nxt;
  logic [7:0]  frm_reg_r, frm_reg_nxt;
  logic [7:0]  frm_data_r, frm_data_nxt;
  logic [2:0]  ntx_r, ntx_nxt;
  logic [2:0]  idx_r, idx_nxt;
  // result slot
  logic        out_valid_r, out_valid_nxt;
  logic        o_tx_valid_r;
  logic [7:0]  o_tx_byte_r;
  logic        o_last_r;
  logic        o_flush_r;
  logic [2:0]  o_used_r;
  logic        o_upd_r;
  logic signed [12:0] o_hv_r;
  logic [2:0]  o_phase_r;
  logic [2:0]  o_ack_r;
  logic [7:0]  o_dev_r;

  logic        out_free;
  logic        emit_more;
  logic        wrap_busy;
  logic [2:0]  ack_used;
  logic [2:0]  ack_code;
  logic [2:0]  rep_code;
  logic [7:0]  wait_dec;
  logic [15:0] raw_sel;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit_more = (idx_r + 3'd1) < ntx_r;
  assign wrap_busy = (hv_r > HALF_TURN) || (hv_r < NEG_HALF_TURN);
  assign wait_dec  = wait_cnt_r - 8'd1;
  assign raw_sel   = (ctl.act == ACT_HEAD_HELD) ? held_raw_r : 16'd0;

  // two-byte ack of a mode write
  always_comb begin
    ack_used = (avail_r < ACK_LEN) ? avail_r : ACK_LEN;
    if (avail_r < ACK_LEN) begin
      ack_code = ACK_SHORT;
    end else if (rxb_r[0] != ERR_BYTE) begin
      ack_code = ACK_HEADER;
    end else if (rxb_r[1] != ACK_GOOD) begin
      ack_code = ACK_DEVICE;
    end else begin
      ack_code = ACK_OK;
    end
  end

  // four-byte heading reply; an error marker always fails
  always_comb begin
    if (avail_r < RX_CAP) begin
      rep_code = ACK_SHORT;
    end else if (rxb_r[0] == ERR_BYTE) begin
      rep_code = ACK_DEVICE;
    end else if (rxb_r[0] != RESP_BYTE || rxb_r[1] != LEN_HEADING) begin
      rep_code = ACK_HEADER;
    end else begin
      rep_code = ACK_OK;
    end
  end

  always_comb begin
    enabled_nxt    = enabled_r;
    wait_ticks_nxt = wait_ticks_r;
    phase_nxt      = phase_r;
    wait_cnt_nxt   = wait_cnt_r;
    held_raw_nxt   = held_raw_r;
    last_raw_nxt   = last_raw_r;
    offset_nxt     = offset_r;
    cmd_nxt        = cmd_r;
    avail_nxt      = avail_r;
    flush_nxt      = flush_r;
    used_nxt       = used_r;
    upd_nxt        = upd_r;
    ack_nxt        = ack_r;
    dev_nxt        = dev_r;
    hv_nxt         = hv_r;
    frm_req_nxt    = frm_req_r;
    frm_reg_nxt    = frm_reg_r;
    frm_data_nxt   = frm_data_r;
    ntx_nxt        = ntx_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    if (cfg_we) begin
      case (cfg_idx)
        CFG_ENABLED: enabled_nxt    = cfg_wdata[0];
        CFG_WAIT:    wait_ticks_nxt = cfg_wdata;
        default:     ;
      endcase
    end

    if (ctl.accept) begin
      cmd_nxt   = in_ch.cmd;
      avail_nxt = (in_ch.rx_count > RX_CAP) ? RX_CAP : in_ch.rx_count;
      flush_nxt = 1'b0;
      used_nxt  = 3'd0;
      upd_nxt   = 1'b0;
      ack_nxt   = ACK_NONE;
      dev_nxt   = 8'd0;
      hv_nxt    = 17'sd0;
      ntx_nxt   = 3'd0;
      idx_nxt   = 3'd0;
    end

    case (ctl.act)
      ACT_ZERO: offset_nxt = last_raw_r;
      ACT_RESTART: begin
        phase_nxt = PH_RESET;
        flush_nxt = enabled_r;
      end
      ACT_T_RESET: begin
        flush_nxt    = 1'b1;
        frm_req_nxt  = 1'b0;
        frm_reg_nxt  = REG_SYS_TRIG;
        frm_data_nxt = VAL_CLK_SEL;
        ntx_nxt      = LEN_WRITE_FRM;
        phase_nxt    = PH_INIT1;
      end
      ACT_T_INIT1: begin
        frm_req_nxt  = 1'b0;
        frm_reg_nxt  = REG_SYS_TRIG;
        frm_data_nxt = VAL_RST_SYS;
        ntx_nxt      = LEN_WRITE_FRM;
        wait_cnt_nxt = wait_ticks_r;
        phase_nxt    = PH_WAIT;
      end
      ACT_T_WAIT: begin
        wait_cnt_nxt = wait_dec;
        if (wait_dec == 8'd0) begin
          phase_nxt = PH_INIT2;
          flush_nxt = 1'b1;
        end
      end
      ACT_T_INIT2: begin
        frm_req_nxt  = 1'b0;
        frm_reg_nxt  = REG_PWR_MODE;
        frm_data_nxt = VAL_PWR_NORM;
        ntx_nxt      = LEN_WRITE_FRM;
        phase_nxt    = PH_INIT3;
      end
      ACT_T_INIT3, ACT_T_INIT4: begin
        used_nxt = ack_used;
        ack_nxt  = ack_code;
        if (ack_code == ACK_DEVICE) dev_nxt = rxb_r[1];
        if (ack_code != ACK_OK) begin
          phase_nxt = PH_ERROR;
        end else if (ctl.act == ACT_T_INIT3) begin
          frm_req_nxt  = 1'b0;
          frm_reg_nxt  = REG_OPR_MODE;
          frm_data_nxt = VAL_MODE_NDOF;
          ntx_nxt      = LEN_WRITE_FRM;
          phase_nxt    = PH_INIT4;
        end else begin
          frm_req_nxt = 1'b1;
          ntx_nxt     = LEN_REQ_FRM;
          phase_nxt   = PH_READY;
        end
      end
      ACT_T_READY: begin
        used_nxt = avail_r;
        ack_nxt  = rep_code;
        if (rep_code == ACK_DEVICE) dev_nxt = rxb_r[1];
        if (rep_code == ACK_OK) held_raw_nxt = {rxb_r[3], rxb_r[2]};
        frm_req_nxt = 1'b1;
        ntx_nxt     = LEN_REQ_FRM;
      end
      ACT_T_ERROR: phase_nxt = PH_RESET;
      ACT_HEAD_ZERO, ACT_HEAD_HELD: begin
        last_raw_nxt = raw_sel;
        hv_nxt       = $signed({1'b0, raw_sel}) - $signed({1'b0, offset_r});
        upd_nxt      = 1'b1;
      end
      ACT_WRAP: begin
        if (hv_r > HALF_TURN) begin
          hv_nxt = hv_r - FULL_TURN;
        end else if (hv_r < NEG_HALF_TURN) begin
          hv_nxt = hv_r + FULL_TURN;
        end
      end
      ACT_EMIT: begin
        out_valid_nxt = 1'b1;
        idx_nxt       = idx_r + 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      wait_ticks_r <= WAIT_TICKS_RST;
      phase_r      <= PH_RESET;
      wait_cnt_r   <= 8'd0;
      held_raw_r   <= 16'd0;
      last_raw_r   <= 16'd0;
      offset_r     <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      enabled_r    <= enabled_nxt;
      wait_ticks_r <= wait_ticks_nxt;
      phase_r      <= phase_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      held_raw_r   <= held_raw_nxt;
      last_raw_r   <= last_raw_nxt;
      offset_r     <= offset_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    avail_r    <= avail_nxt;
    flush_r    <= flush_nxt;
    used_r     <= used_nxt;
    upd_r      <= upd_nxt;
    ack_r      <= ack_nxt;
    dev_r      <= dev_nxt;
    hv_r       <= hv_nxt;
    frm_req_r  <= frm_req_nxt;
    frm_reg_r  <= frm_reg_nxt;
    frm_data_r <= frm_data_nxt;
    ntx_r      <= ntx_nxt;
    idx_r      <= idx_nxt;
    if (ctl.accept) begin
      rxb_r[0] <= in_ch.rx_byte0;
      rxb_r[1] <= in_ch.rx_byte1;
      rxb_r[2] <= in_ch.rx_byte2;
      rxb_r[3] <= in_ch.rx_byte3;
    end
  end

  // result slot load; status fields ride only on the final result
  always_ff @(posedge clk) begin
    if (ctl.act == ACT_EMIT) begin
      o_tx_valid_r <= (ntx_r != 3'd0);
      o_tx_byte_r  <= (ntx_r != 3'd0) ?
                      frame_byte(frm_req_r, frm_reg_r, frm_data_r, idx_r) : 8'h00;
      o_last_r     <= !emit_more;
      o_flush_r    <= !emit_more && flush_r;
      o_used_r     <= emit_more ? 3'd0 : used_r;
      o_upd_r      <= !emit_more && upd_r;
      o_hv_r       <= emit_more ? 13'sd0 : hv_r[12:0];
      o_phase_r    <= emit_more ? PH_RESET : phase_r;
      o_ack_r      <= emit_more ? ACK_NONE : ack_r;
      o_dev_r      <= emit_more ? 8'd0 : dev_r;
    end
  end

  assign in_ch.ready           = ctl.rdy;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.tx_valid       = o_tx_valid_r;
  assign out_ch.tx_byte        = o_tx_byte_r;
  assign out_ch.last           = o_last_r;
  assign out_ch.flush_rx       = o_flush_r;
  assign out_ch.rx_consumed    = o_used_r;
  assign out_ch.heading_update = o_upd_r;
  assign out_ch.heading_value  = o_hv_r;
  assign out_ch.phase_code     = o_phase_r;
  assign out_ch.ack_status     = o_ack_r;
  assign out_ch.device_code    = o_dev_r;

  assign stat.in_valid  = in_ch.valid;
  assign stat.out_free  = out_free;
  assign stat.cmd       = cmd_r;
  assign stat.enabled   = enabled_r;
  assign stat.phase     = phase_r;
  assign stat.wrap_busy = wrap_busy;
  assign stat.emit_more = emit_more;

`ifndef SYNTHESIS
  a_emit_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.act == ACT_EMIT) |-> !wrap_busy)
    else $error("heading emitted before wrap finished");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.act == ACT_EMIT) |-> out_free)
    else $error("result loaded into occupied slot");

  a_ack_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.act == ACT_EMIT && ack_r != ACK_NONE) |-> upd_r)
    else $error("ack status reported without a tick");
`endif

endmodule

/* rtl/core/uart_imu_heading_poller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_imu_heading_poller_unit: UART orientation sensor heading poller
// Microcoded sequencer driving a datapath that builds sensor frames, checks
// replies and reports the zero-corrected heading.
//
//   port    dir  handshake         carries
//   in_ch   in   valid/ready       cmd, rx_count, rx_byte0..3
//   out_ch  out  valid/ready       one frame byte per beat; status on the last beat
//   cfg_*   in   cfg_we strobe     tracker_enabled (idx 0), reset_wait_ticks (idx 1)
//
// One command at a time. A zero/restart/idle command emits one result; an
//   enabled tick runs k (0..11) wrap passes of the shared add/subtract of a
//   full turn on the heading difference, then emits max(1, n) results, where
//   n is the frame length (0, 4 or 5).
// Results leave through a one-deep output register; the emit step holds while
// that register is occupied and not taken.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module uart_imu_heading_poller_unit
  import uihp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  uihp_in_if.sink     in_ch,
  uihp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_wdata
);

  uihp_ctl_t  ctl;
  uihp_stat_t stat;

  uihp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  uihp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule
